/* hw/rtl/typed_trigger_packet_parser_defines.svh */
// Assertion macros shared by the parser RTL.
`ifndef TYPED_TRIGGER_PACKET_PARSER_DEFINES_SVH
`define TYPED_TRIGGER_PACKET_PARSER_DEFINES_SVH

`ifndef SYNTHESIS

// Condition that must hold at every clock edge out of reset.
`define TTPP_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Condition in one cycle that implies another in the next cycle.
`define TTPP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`else

`define TTPP_ASSERT(label, cond, msg)
`define TTPP_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

/* hw/rtl/ttpp_pkg.sv */
// Types and constants shared by the typed trigger packet parser.
`timescale 1ns / 1ps
`default_nettype none

package ttpp_pkg;

  localparam int MaxPayload = 4096;
  localparam int MaxValues  = 16;
  localparam int HeaderLen  = 12;
  localparam int QueueDepth = 4;

  localparam int CountW  = 5;
  localparam int KindsW  = 16;
  localparam int SlotW   = 5;
  localparam int TextW   = 12;

  localparam logic [7:0] ChildBias   = 8'd128;
  localparam logic [7:0] GroupMask   = 8'h7f;
  localparam logic [7:0] ContBit     = 8'h80;
  localparam logic [7:0] OvfMask     = 8'hf0;
  localparam int         LastShift   = 28;

  typedef enum logic [1:0] {
    CFG_PRESENT = 2'd0,
    CFG_COUNT   = 2'd1,
    CFG_KINDS   = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    KIND_HEADER = 2'd0,
    KIND_INT    = 2'd1,
    KIND_STRING = 2'd2,
    KIND_STATUS = 2'd3
  } kind_t;

  typedef struct packed {
    kind_t        kind;
    logic [15:0]  child;
    logic [15:0]  object_num;
    logic [31:0]  component_num;
    logic [31:0]  check_val;
    logic [3:0]   slot;
    logic [31:0]  int_val;
    logic [11:0]  text_off;
    logic [11:0]  text_len;
    logic         ok;
    logic         last_res;
  } result_t;

  // One queue word: what a single input byte produced.
  typedef struct packed {
    logic    has_value;
    result_t value;
    logic    has_status;
    logic    status_ok;
  } entry_t;

endpackage

`default_nettype wire

/* hw/rtl/ttpp_front.sv */
// Front end: configuration registers and per-byte header and value decode.
`timescale 1ns / 1ps
`default_nettype none

module ttpp_front #(
  parameter int MaxPayload = ttpp_pkg::MaxPayload
) (
  input  wire                   clk,
  input  wire                   rst,
  input  wire                   cfg_valid,
  output logic                  cfg_ready,
  input  wire  [1:0]            cfg_index,
  input  wire  [15:0]           cfg_data,
  input  wire                   byte_valid,
  output logic                  byte_ready,
  input  wire  [7:0]            data_byte,
  input  wire                   last_byte,
  input  wire                   queue_full,
  output logic                  push,
  output ttpp_pkg::entry_t      push_entry
);

  localparam int PosW = $clog2(MaxPayload + 1);
  localparam logic [PosW-1:0] PosMax     = PosW'(MaxPayload);
  localparam logic [PosW-1:0] PosHdr     = PosW'(ttpp_pkg::HeaderLen);
  localparam logic [PosW-1:0] PosHdrLast = PosW'(ttpp_pkg::HeaderLen - 1);
  localparam int SlotW = ttpp_pkg::SlotW;
  localparam int TextW = ttpp_pkg::TextW;

  logic                          sig_present;
  logic [ttpp_pkg::CountW-1:0]   sig_count;
  logic [ttpp_pkg::KindsW-1:0]   sig_kinds;

  logic [PosW-1:0]  pos, pos_next;
  logic [SlotW-1:0] slot, slot_next;
  logic [31:0]      acc, acc_next;
  logic [2:0]       grp, grp_next;
  logic [TextW-1:0] tstart, tstart_next;
  logic             err, err_next;
  logic             done, done_next;

  logic [15:0] held_child;
  logic [15:0] held_object;
  logic [31:0] held_component;
  logic [23:0] held_check;

  logic             accept;
  logic             is_int;
  logic             grp_ovf;
  logic [31:0]      shifted;
  logic [31:0]      acc_new;
  logic [31:0]      zz;
  logic [TextW-1:0] off;
  logic [SlotW-1:0] slot_inc;
  logic             finish;
  ttpp_pkg::entry_t entry;

  assign cfg_ready  = 1'b1;
  assign byte_ready = !queue_full;
  assign accept     = byte_valid && byte_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      sig_present <= 1'b0;
      sig_count   <= '0;
      sig_kinds   <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        ttpp_pkg::CFG_PRESENT: sig_present <= cfg_data[0];
        ttpp_pkg::CFG_COUNT:   sig_count   <= cfg_data[ttpp_pkg::CountW-1:0];
        ttpp_pkg::CFG_KINDS:   sig_kinds   <= cfg_data[ttpp_pkg::KindsW-1:0];
        default: ;
      endcase
    end
  end

  // Varint group placement: seven bits per group, the fifth keeps four.
  always_comb begin
    case (grp)
      3'd0:    shifted = {25'd0, data_byte[6:0]};
      3'd1:    shifted = {18'd0, data_byte[6:0], 7'd0};
      3'd2:    shifted = {11'd0, data_byte[6:0], 14'd0};
      3'd3:    shifted = {4'd0, data_byte[6:0], 21'd0};
      3'd4:    shifted = {data_byte[3:0], ttpp_pkg::LastShift'(0)};
      default: shifted = '0;
    endcase
  end

  assign is_int   = (slot < SlotW'(ttpp_pkg::KindsW)) && sig_kinds[slot[3:0]];
  assign grp_ovf  = (grp >= 3'd4) && ((data_byte & ttpp_pkg::OvfMask) != 8'd0);
  assign acc_new  = acc | shifted;
  assign zz       = {1'b0, acc_new[31:1]} ^ {32{acc_new[0]}};
  assign off      = TextW'(pos) - TextW'(ttpp_pkg::HeaderLen);
  assign slot_inc = slot + SlotW'(1);

  always_comb begin
    pos_next    = pos;
    slot_next   = slot;
    acc_next    = acc;
    grp_next    = grp;
    tstart_next = tstart;
    err_next    = err;
    done_next   = done;
    finish      = 1'b0;
    entry       = '0;

    if (pos >= PosMax) begin
      err_next = 1'b1;
    end else begin
      if (pos < PosHdr) begin
        if (pos == PosHdrLast) begin
          entry.has_value            = 1'b1;
          entry.value.kind           = ttpp_pkg::KIND_HEADER;
          entry.value.child          = held_child;
          entry.value.object_num     = held_object;
          entry.value.component_num  = held_component;
          entry.value.check_val      = {data_byte, held_check};
          slot_next   = '0;
          acc_next    = '0;
          grp_next    = '0;
          tstart_next = '0;
          done_next   = (sig_count == '0);
        end
      end else if (sig_present && !err) begin
        if (done) begin
          // anything past the last value is trailing garbage
          err_next = 1'b1;
        end else if (is_int) begin
          if (grp_ovf) begin
            err_next = 1'b1;
          end else if ((data_byte & ttpp_pkg::ContBit) == 8'd0) begin
            entry.has_value      = 1'b1;
            entry.value.kind     = ttpp_pkg::KIND_INT;
            entry.value.slot     = slot[3:0];
            entry.value.int_val  = zz;
            finish               = 1'b1;
          end else begin
            acc_next = acc_new;
            grp_next = grp + 3'd1;
          end
        end else if (data_byte == 8'd0) begin
          entry.has_value      = 1'b1;
          entry.value.kind     = ttpp_pkg::KIND_STRING;
          entry.value.slot     = slot[3:0];
          entry.value.text_off = tstart;
          entry.value.text_len = off - tstart;
          finish               = 1'b1;
        end
      end
      if (finish) begin
        slot_next   = slot_inc;
        acc_next    = '0;
        grp_next    = '0;
        tstart_next = off + TextW'(1);
        if (slot_inc >= SlotW'(sig_count)) begin
          done_next = 1'b1;
        end else if ({1'b0, slot_inc} >= (SlotW+1)'(ttpp_pkg::MaxValues)) begin
          err_next = 1'b1;
        end
      end
      pos_next = pos + PosW'(1);
    end

    if (last_byte) begin
      entry.has_status = 1'b1;
      entry.status_ok  = !err_next && (pos_next >= PosHdr) && (!sig_present || done_next);
      pos_next    = '0;
      slot_next   = '0;
      acc_next    = '0;
      grp_next    = '0;
      tstart_next = '0;
      err_next    = 1'b0;
      done_next   = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      slot   <= '0;
      acc    <= '0;
      grp    <= '0;
      tstart <= '0;
      err    <= 1'b0;
      done   <= 1'b0;
    end else if (accept) begin
      pos    <= pos_next;
      slot   <= slot_next;
      acc    <= acc_next;
      grp    <= grp_next;
      tstart <= tstart_next;
      err    <= err_next;
      done   <= done_next;
    end
  end

  // Header capture; every byte is overwritten before the header goes out.
  always_ff @(posedge clk) begin
    if (accept && (pos < PosHdr)) begin
      case (4'(pos))
        4'd0:    held_child[7:0]        <= data_byte - ttpp_pkg::ChildBias;
        4'd1:    held_child[15:8]       <= data_byte;
        4'd2:    held_object[15:8]      <= data_byte;
        4'd3:    held_object[7:0]       <= data_byte;
        4'd4:    held_component[7:0]    <= data_byte;
        4'd5:    held_component[15:8]   <= data_byte;
        4'd6:    held_component[23:16]  <= data_byte;
        4'd7:    held_component[31:24]  <= data_byte;
        4'd8:    held_check[7:0]        <= data_byte;
        4'd9:    held_check[15:8]       <= data_byte;
        4'd10:   held_check[23:16]      <= data_byte;
        default: ;
      endcase
    end
  end

  assign push       = accept && (entry.has_value || entry.has_status);
  assign push_entry = entry;

endmodule

`default_nettype wire

/* hw/rtl/ttpp_queue.sv */
// Short word queue between the decode front end and the result back end.
`timescale 1ns / 1ps
`default_nettype none

`include "typed_trigger_packet_parser_defines.svh"

module ttpp_queue (
  input  wire               clk,
  input  wire               rst,
  input  wire               push,
  input  ttpp_pkg::entry_t  push_entry,
  input  wire               pop,
  output logic              full,
  output logic              head_valid,
  output ttpp_pkg::entry_t  head
);

  localparam int Depth = ttpp_pkg::QueueDepth;
  localparam int AddrW = $clog2(Depth);
  localparam int CntW  = $clog2(Depth + 1);

  ttpp_pkg::entry_t slots [Depth];
  logic [AddrW-1:0] wr_ptr;
  logic [AddrW-1:0] rd_ptr;
  logic [CntW-1:0]  count;

  assign full       = (count == CntW'(Depth));
  assign head_valid = (count != '0);
  assign head       = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == AddrW'(Depth - 1)) ? '0 : wr_ptr + AddrW'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == AddrW'(Depth - 1)) ? '0 : rd_ptr + AddrW'(1);
      end
      case ({push, pop})
        2'b10:   count <= count + CntW'(1);
        2'b01:   count <= count - CntW'(1);
        default: ;
      endcase
    end
  end

  `TTPP_ASSERT(a_no_push_when_full, !(push && full), "queue written while full")
  `TTPP_ASSERT(a_count_in_range, count <= CntW'(Depth), "queue count beyond depth")
  `TTPP_ASSERT(a_no_pop_when_empty, !(pop && !head_valid), "queue read while empty")

endmodule

`default_nettype wire

/* hw/rtl/ttpp_back.sv */
// Back end: splits queue words into results and holds them in the output register.
`timescale 1ns / 1ps
`default_nettype none

`include "typed_trigger_packet_parser_defines.svh"

module ttpp_back (
  input  wire                  clk,
  input  wire                  rst,
  input  wire                  head_valid,
  input  ttpp_pkg::entry_t     head,
  output logic                 pop,
  output logic                 result_valid,
  input  wire                  result_ready,
  output logic [1:0]           result_kind,
  output logic signed [15:0]   child_field,
  output logic [15:0]          object_number,
  output logic signed [31:0]   component_number,
  output logic signed [31:0]   check_word,
  output logic [3:0]           value_slot,
  output logic signed [31:0]   integer_value,
  output logic [11:0]          text_offset,
  output logic [11:0]          text_length,
  output logic                 parse_ok,
  output logic                 final_result
);

  ttpp_pkg::result_t res;
  ttpp_pkg::result_t chosen;
  logic              second;
  logic              load;
  logic              take_value;

  assign load       = head_valid && (!result_valid || result_ready);
  assign take_value = head.has_value && !second;

  always_comb begin
    if (take_value) begin
      chosen = head.value;
    end else begin
      chosen          = '0;
      chosen.kind     = ttpp_pkg::KIND_STATUS;
      chosen.ok       = head.status_ok;
      chosen.last_res = 1'b1;
    end
  end

  // Hold the word in the queue while its status result is still to come.
  assign pop = load && !(take_value && head.has_status);

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
      second       <= 1'b0;
    end else begin
      if (load) begin
        result_valid <= 1'b1;
        second       <= take_value && head.has_status;
      end else if (result_ready) begin
        result_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      res <= chosen;
    end
  end

  assign result_kind      = res.kind;
  assign child_field      = $signed(res.child);
  assign object_number    = res.object_num;
  assign component_number = $signed(res.component_num);
  assign check_word       = $signed(res.check_val);
  assign value_slot       = res.slot;
  assign integer_value    = $signed(res.int_val);
  assign text_offset      = res.text_off;
  assign text_length      = res.text_len;
  assign parse_ok         = res.ok;
  assign final_result     = res.last_res;

  `TTPP_ASSERT(a_second_has_status, !second || (head_valid && head.has_status),
               "pending status without a queued status word")
  `TTPP_ASSERT(a_final_is_status,
               !result_valid || (final_result == (res.kind == ttpp_pkg::KIND_STATUS)),
               "final mark disagrees with result kind")
  `TTPP_ASSERT_NEXT(a_split_follows, load && take_value && head.has_status,
                    second && head_valid, "value and status split lost its status")

endmodule

`default_nettype wire

/* hw/rtl/typed_trigger_packet_parser.sv */
// Path: results of an accepted byte go into the queue, then into the output register.
// Throughput: one byte per cycle unless the queue is full; a byte ending both a value
//   and the payload yields two results, absorbed by a 4-word queue.
// Results: one per cycle while result_ready is high, set by the single output register.
// Reset: synchronous active-high rst clears signature registers, parse state, the queue
//   and the output valid.
`timescale 1ns / 1ps
`default_nettype none

module typed_trigger_packet_parser #(
  parameter int MaxPayload = ttpp_pkg::MaxPayload
) (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 cfg_valid,
  output logic                cfg_ready,
  input  wire  [1:0]          cfg_index,
  input  wire  [15:0]         cfg_data,
  input  wire                 byte_valid,
  output logic                byte_ready,
  input  wire  [7:0]          data_byte,
  input  wire                 last_byte,
  output logic                result_valid,
  input  wire                 result_ready,
  output logic [1:0]          result_kind,
  output logic signed [15:0]  child_field,
  output logic [15:0]         object_number,
  output logic signed [31:0]  component_number,
  output logic signed [31:0]  check_word,
  output logic [3:0]          value_slot,
  output logic signed [31:0]  integer_value,
  output logic [11:0]         text_offset,
  output logic [11:0]         text_length,
  output logic                parse_ok,
  output logic                final_result
);

  logic             push;
  logic             pop;
  logic             queue_full;
  logic             head_valid;
  ttpp_pkg::entry_t push_entry;
  ttpp_pkg::entry_t head;

  ttpp_front #(
    .MaxPayload(MaxPayload)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .byte_valid (byte_valid),
    .byte_ready (byte_ready),
    .data_byte  (data_byte),
    .last_byte  (last_byte),
    .queue_full (queue_full),
    .push       (push),
    .push_entry (push_entry)
  );

  ttpp_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .full       (queue_full),
    .head_valid (head_valid),
    .head       (head)
  );

  ttpp_back u_back (
    .clk              (clk),
    .rst              (rst),
    .head_valid       (head_valid),
    .head             (head),
    .pop              (pop),
    .result_valid     (result_valid),
    .result_ready     (result_ready),
    .result_kind      (result_kind),
    .child_field      (child_field),
    .object_number    (object_number),
    .component_number (component_number),
    .check_word       (check_word),
    .value_slot       (value_slot),
    .integer_value    (integer_value),
    .text_offset      (text_offset),
    .text_length      (text_length),
    .parse_ok         (parse_ok),
    .final_result     (final_result)
  );

endmodule

`default_nettype wire
